// ===== hdl/mcpd_pkg.sv =====
// Shared types and constants for the motion command packet dispatcher.
// No dependencies; imported by the byte RAM, the sequencer and the top module.
`timescale 1ns / 1ps
`default_nettype none
package mcpd_pkg;

  localparam int BYTE_W = 8;
  localparam int WORD_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int SR_W = 4 * WORD_W;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_SLICE  = 2'd1;
  localparam logic [1:0] OP_QRESET = 2'd2;

  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_MOVE   = 2'd1;
  localparam logic [1:0] ACT_SETPOS = 2'd2;
  localparam logic [1:0] ACT_DELAY  = 2'd3;

  localparam logic [1:0] MODE_READY  = 2'd0;
  localparam logic [1:0] MODE_MOVING = 2'd1;
  localparam logic [1:0] MODE_DELAY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_OPC_MOVE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OPC_SETPOS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OPC_DELAY  = 2'd2;

  localparam logic [BYTE_W-1:0] OPC_MOVE_RST   = 8'd129;
  localparam logic [BYTE_W-1:0] OPC_SETPOS_RST = 8'd130;
  localparam logic [BYTE_W-1:0] OPC_DELAY_RST  = 8'd133;

  localparam int LEN_MOVE   = 17;
  localparam int LEN_SETPOS = 13;
  localparam int LEN_DELAY  = 5;

  typedef struct packed {
    logic [BYTE_W-1:0] move;
    logic [BYTE_W-1:0] setpos;
    logic [BYTE_W-1:0] delay;
  } opcodes_t;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [WORD_W-1:0] pos_x;
    logic signed [WORD_W-1:0] pos_y;
    logic signed [WORD_W-1:0] pos_z;
    logic signed [WORD_W-1:0] step_interval;
    logic [WORD_W-1:0]        delay_us;
    logic [1:0]               mode_now;
    logic                     byte_dropped;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/mcpd_in_if.sv =====
// Input item channel: valid/ready handshake with the command fields.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface mcpd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] data_byte;
  logic       motion_running;
  logic       delay_elapsed;
  logic       paused;

  modport source (output valid, operation, data_byte, motion_running, delay_elapsed,
                  paused, input ready);
  modport sink (input valid, operation, data_byte, motion_running, delay_elapsed,
                paused, output ready);
endinterface
`default_nettype wire

// ===== hdl/mcpd_out_if.sv =====
// Result item channel: valid/ready handshake with action and packet words.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface mcpd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] step_interval;
  logic [31:0]        delay_us;
  logic [1:0]         mode_now;
  logic               byte_dropped;

  modport source (output valid, action, pos_x, pos_y, pos_z, step_interval, delay_us,
                  mode_now, byte_dropped, input ready);
  modport sink (input valid, action, pos_x, pos_y, pos_z, step_interval, delay_us,
                mode_now, byte_dropped, output ready);
endinterface
`default_nettype wire

// ===== hdl/mcpd_cfg_if.sv =====
// Configuration write channel: valid/ready, register index and write data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface mcpd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface
`default_nettype wire

// ===== hdl/mcpd_byte_ram.sv =====
// Byte queue storage: one write port, one read port with registered data.
// Depends on mcpd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mcpd_byte_ram
  import mcpd_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [BYTE_W-1:0] wr_data,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== hdl/mcpd_seq.sv =====
// Queue pointers, mode machine and packet pop sequencer around the byte RAM.
// Depends on mcpd_pkg and mcpd_in_if.
`timescale 1ns / 1ps
`default_nettype none
module mcpd_seq
  import mcpd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 256,
  parameter int AW          = 8,
  parameter int CW          = 9
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  mcpd_in_if.sink                in_chan,
  input  wire opcodes_t          opc,
  output logic                   mem_wr_en,
  output logic      [AW-1:0]     mem_wr_addr,
  output logic      [BYTE_W-1:0] mem_wr_data,
  output logic      [AW-1:0]     mem_rd_addr,
  input  wire logic [BYTE_W-1:0] mem_rd_data,
  output result_t                res,
  output logic                   res_valid,
  input  wire logic              res_take
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_OPC     = 3'd1;
  localparam logic [2:0] S_COLLECT = 3'd2;
  localparam logic [2:0] S_DRAIN   = 3'd3;
  localparam logic [2:0] S_DONE    = 3'd4;

  localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);

  logic [2:0]      state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [AW-1:0]   tail_r, tail_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [1:0]      mode_r, mode_nxt;
  logic [4:0]      left_r, left_nxt;
  logic            rd_pend_r, rd_pend_nxt;
  logic [1:0]      act_r, act_nxt;
  logic            drop_r, drop_nxt;
  logic [SR_W-1:0] sr_r, sr_nxt;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == LAST_ADDR) ? '0 : p + AW'(1);
  endfunction

  assign in_chan.ready = (state_r == S_IDLE);
  assign mem_rd_addr   = head_r;
  assign mem_wr_addr   = tail_r;
  assign mem_wr_data   = in_chan.data_byte;
  assign res_valid     = (state_r == S_DONE);

  always_comb begin
    logic [1:0]    m;
    logic [1:0]    act;
    logic [CW-1:0] len;
    state_nxt   = state_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    mode_nxt    = mode_r;
    left_nxt    = left_r;
    rd_pend_nxt = 1'b0;
    act_nxt     = act_r;
    drop_nxt    = drop_r;
    sr_nxt      = sr_r;
    mem_wr_en   = 1'b0;
    m           = mode_r;
    act         = ACT_NONE;
    len         = '0;
    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          act_nxt   = ACT_NONE;
          drop_nxt  = 1'b0;
          state_nxt = S_DONE;
          case (in_chan.operation)
            OP_PUSH: begin
              if (count_r == CW'(QUEUE_DEPTH)) begin
                drop_nxt = 1'b1;
              end else begin
                mem_wr_en = 1'b1;
                tail_nxt  = ptr_inc(tail_r);
                count_nxt = count_r + CW'(1);
              end
            end
            OP_QRESET: begin
              head_nxt  = '0;
              tail_nxt  = '0;
              count_nxt = '0;
              mode_nxt  = MODE_READY;
            end
            OP_SLICE: begin
              if (!in_chan.paused) begin
                if (m == MODE_MOVING && !in_chan.motion_running) m = MODE_READY;
                if (m == MODE_DELAY && in_chan.delay_elapsed) m = MODE_READY;
                mode_nxt = m;
                if (m == MODE_READY && count_r != '0) state_nxt = S_OPC;
              end
            end
            default: ;
          endcase
        end
      end
      S_OPC: begin
        if (mem_rd_data == opc.move) begin
          act = ACT_MOVE;
          len = CW'(LEN_MOVE);
        end else if (mem_rd_data == opc.setpos) begin
          act = ACT_SETPOS;
          len = CW'(LEN_SETPOS);
        end else if (mem_rd_data == opc.delay) begin
          act = ACT_DELAY;
          len = CW'(LEN_DELAY);
        end
        if (act != ACT_NONE && count_r >= len) begin
          act_nxt   = act;
          head_nxt  = ptr_inc(head_r);
          count_nxt = count_r - CW'(1);
          left_nxt  = 5'(len - CW'(1));
          state_nxt = S_COLLECT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_COLLECT: begin
        head_nxt    = ptr_inc(head_r);
        count_nxt   = count_r - CW'(1);
        left_nxt    = left_r - 5'd1;
        rd_pend_nxt = 1'b1;
        if (rd_pend_r) sr_nxt = {mem_rd_data, sr_r[SR_W-1:BYTE_W]};
        if (left_r == 5'd1) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        sr_nxt = {mem_rd_data, sr_r[SR_W-1:BYTE_W]};
        if (act_r == ACT_MOVE) mode_nxt = MODE_MOVING;
        else if (act_r == ACT_DELAY) mode_nxt = MODE_DELAY;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_take) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    res              = '0;
    res.action       = act_r;
    res.mode_now     = mode_r;
    res.byte_dropped = drop_r;
    case (act_r)
      ACT_MOVE: begin
        res.pos_x         = sr_r[31:0];
        res.pos_y         = sr_r[63:32];
        res.pos_z         = sr_r[95:64];
        res.step_interval = sr_r[127:96];
      end
      ACT_SETPOS: begin
        res.pos_x = sr_r[63:32];
        res.pos_y = sr_r[95:64];
        res.pos_z = sr_r[127:96];
      end
      ACT_DELAY: res.delay_us = sr_r[127:96];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      mode_r    <= MODE_READY;
      left_r    <= '0;
      rd_pend_r <= 1'b0;
      act_r     <= ACT_NONE;
      drop_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      mode_r    <= mode_nxt;
      left_r    <= left_nxt;
      rd_pend_r <= rd_pend_nxt;
      act_r     <= act_nxt;
      drop_r    <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sr_r <= sr_nxt;
  end

endmodule
`default_nettype wire

// ===== hdl/motion_command_packet_dispatcher.sv =====
// Motion command packet dispatcher. Host bytes go into a single-port-read byte
// queue RAM; run-slice items advance the ready/moving/delay mode and, when a full
// packet sits at the head, pop it one byte per cycle and issue move, set position
// or delay. One item at a time: push, queue reset, paused or idle slices go
// straight to the result register; a slice that finds a short packet or an
// unknown opcode at the head takes one extra step for the head read; a slice
// that pops a packet reads the opcode, collects the packet bytes one by one and
// drains the last read, paced by the one byte read port of the queue RAM. The
// result register lets the next item in while a result waits. No reset sweep:
// queue entries are only read once written.
`timescale 1ns / 1ps
`default_nettype none
module motion_command_packet_dispatcher
  import mcpd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 256
) (
  input wire logic  clk,
  input wire logic  rst_n,
  mcpd_in_if.sink   in_chan,
  mcpd_out_if.source out_chan,
  mcpd_cfg_if.sink  cfg_chan
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  opcodes_t          opc_r;
  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  logic [BYTE_W-1:0] mem_wr_data;
  logic [AW-1:0]     mem_rd_addr;
  logic [BYTE_W-1:0] mem_rd_data;
  result_t           res;
  logic              res_valid;
  logic              res_take;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_r;

  mcpd_byte_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  mcpd_seq #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .opc         (opc_r),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .res         (res),
    .res_valid   (res_valid),
    .res_take    (res_take)
  );

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opc_r.move   <= OPC_MOVE_RST;
      opc_r.setpos <= OPC_SETPOS_RST;
      opc_r.delay  <= OPC_DELAY_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_OPC_MOVE:   opc_r.move   <= cfg_chan.wdata;
        CFG_OPC_SETPOS: opc_r.setpos <= cfg_chan.wdata;
        CFG_OPC_DELAY:  opc_r.delay  <= cfg_chan.wdata;
        default: ;
      endcase
    end
  end

  assign res_take = !out_valid_r || out_chan.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_take) out_valid_nxt = 1'b1;
    else if (out_chan.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) out_r <= res;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.action        = out_r.action;
  assign out_chan.pos_x         = out_r.pos_x;
  assign out_chan.pos_y         = out_r.pos_y;
  assign out_chan.pos_z         = out_r.pos_z;
  assign out_chan.step_interval = out_r.step_interval;
  assign out_chan.delay_us      = out_r.delay_us;
  assign out_chan.mode_now      = out_r.mode_now;
  assign out_chan.byte_dropped  = out_r.byte_dropped;

endmodule
`default_nettype wire
